// ----- rtl/core/mrd_pkg.sv -----
// Shared types and constants of the meter response deframer.
package mrd_pkg;

  localparam logic [7:0] START_MARK  = 8'h68;
  localparam logic [7:0] END_MARK    = 8'h16;
  localparam logic [7:0] DATA_OFFSET = 8'h33;

  localparam int CTRL_DIR_BIT = 7;
  localparam int CTRL_EXC_BIT = 6;

  localparam logic [9:0] FRAME_OVERHEAD = 10'd12;
  localparam logic [9:0] MIN_FULL_SIZE  = 10'd16;
  localparam logic [9:0] MIN_EXC_SIZE   = 10'd13;

  localparam logic [8:0] POS_START   = 9'd0;
  localparam logic [8:0] POS_MARK2   = 9'd7;
  localparam logic [8:0] POS_CTRL    = 9'd8;
  localparam logic [8:0] POS_LEN     = 9'd9;
  localparam logic [8:0] POS_ID0     = 9'd10;
  localparam logic [8:0] POS_ID3     = 9'd13;
  localparam logic [8:0] POS_PAYLOAD = 9'd14;
  localparam logic [8:0] POS_MAX     = 9'h1FF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXCEPTION = 3'd1,
    ST_SHORT     = 3'd2,
    ST_MARKER    = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_CONTROL   = 3'd5,
    ST_LENGTH    = 3'd6,
    ST_ID        = 3'd7
  } mrd_status_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    mrd_status_t frame_status;
    logic [7:0]  exception_code;
    logic [7:0]  payload_length;
  } mrd_result_t;

endpackage

// ----- rtl/core/meter_response_deframer.sv -----
// Top level of the meter response deframer.
// Usage:
// The input channel carries one frame byte per transfer (in_rx_byte) with
// in_frame_end high on the final byte of the frame.
// The result channel carries either a payload byte with the 0x33 offset
// removed (out_is_status low) or, for the final byte, the frame status,
// exception code and payload count (out_is_status high).
// Payload bytes are only meaningful when the closing status is ok.
// cfg_we writes cfg_wdata as the expected data identifier; write it only
// while no frame is in progress.
// Throughput is one byte per cycle while in_stall is low; every check is a
// compare or an 8-bit add on the byte just taken, so no loop limits the rate.
// Each result is registered in the result queue before out_valid shows it.
// Results wait in a two-entry queue; in_stall rises only when both entries
// are occupied, so a stalled receiver backs up the input after two results.
// Reset clears the frame state, the queue and the identifier register.
module meter_response_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_status,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_frame_status,
  output logic [7:0]  out_exception_code,
  output logic [7:0]  out_payload_length
);
  import mrd_pkg::*;

  logic        acc;
  logic        full;
  logic        res_valid;
  mrd_result_t res;
  mrd_result_t head;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  mrd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .rx_byte   (in_rx_byte),
    .frame_end (in_frame_end),
    .res_valid (res_valid),
    .res       (res)
  );

  mrd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign out_is_status      = head.is_status;
  assign out_payload_byte   = head.payload_byte;
  assign out_frame_status   = head.frame_status;
  assign out_exception_code = head.exception_code;
  assign out_payload_length = head.payload_length;

endmodule

// ----- rtl/core/mrd_frame.sv -----
// Frame tracking state, field checks and per-byte result generation.
module mrd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                acc,
  input  logic [7:0]          rx_byte,
  input  logic                frame_end,
  output logic                res_valid,
  output mrd_pkg::mrd_result_t res
);
  import mrd_pkg::*;

  logic [31:0] id_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic        mark2_ok_r, mark2_ok_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        id_ok_r, id_ok_nxt;
  logic [7:0]  emitted_r, emitted_nxt;

  logic [9:0]  n_size;
  logic [9:0]  exp_size;
  logic [9:0]  payload_end;
  logic        markers;
  logic [7:0]  stripped;
  logic [1:0]  id_sel;
  logic [7:0]  want;
  logic        same;

  assign n_size      = {1'b0, pos_r} + 10'd1;
  assign exp_size    = {2'b00, len_r} + FRAME_OVERHEAD;
  assign payload_end = {2'b00, len_r} + {1'b0, POS_ID0};
  assign markers     = start_ok_r && mark2_ok_r && (rx_byte == END_MARK);
  assign stripped    = rx_byte - DATA_OFFSET;
  assign id_sel      = pos_r[1:0] - POS_ID0[1:0];
  assign want        = id_r[{id_sel, 3'b000} +: 8];
  assign same        = (stripped == want);

  always_comb begin
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    prev_nxt     = prev_r;
    start_ok_nxt = start_ok_r;
    mark2_ok_nxt = mark2_ok_r;
    ctrl_nxt     = ctrl_r;
    len_nxt      = len_r;
    first_nxt    = first_r;
    id_ok_nxt    = id_ok_r;
    emitted_nxt  = emitted_r;
    res_valid    = 1'b0;
    res.is_status      = 1'b0;
    res.payload_byte   = 8'd0;
    res.frame_status   = ST_OK;
    res.exception_code = 8'd0;
    res.payload_length = emitted_r;

    if (acc && frame_end) begin
      res_valid     = 1'b1;
      res.is_status = 1'b1;
      if (n_size < MIN_FULL_SIZE) begin
        if ((n_size >= MIN_EXC_SIZE) && (n_size == exp_size) && markers &&
            ctrl_r[CTRL_EXC_BIT]) begin
          res.frame_status   = ST_EXCEPTION;
          res.exception_code = first_r - DATA_OFFSET;
        end else begin
          res.frame_status = ST_SHORT;
        end
      end else if (!markers) begin
        res.frame_status = ST_MARKER;
      end else if (sum_r != prev_r) begin
        res.frame_status = ST_CHECKSUM;
      end else if (!ctrl_r[CTRL_DIR_BIT]) begin
        res.frame_status = ST_CONTROL;
      end else if (n_size != exp_size) begin
        res.frame_status = ST_LENGTH;
      end else if (!id_ok_r) begin
        res.frame_status = ST_ID;
      end
      pos_nxt      = '0;
      sum_nxt      = '0;
      prev_nxt     = '0;
      start_ok_nxt = 1'b0;
      mark2_ok_nxt = 1'b0;
      ctrl_nxt     = '0;
      len_nxt      = '0;
      first_nxt    = '0;
      id_ok_nxt    = 1'b0;
      emitted_nxt  = '0;
    end else if (acc) begin
      if (pos_r == POS_START) start_ok_nxt = (rx_byte == START_MARK);
      if (pos_r == POS_MARK2) mark2_ok_nxt = (rx_byte == START_MARK);
      if (pos_r == POS_CTRL)  ctrl_nxt = rx_byte;
      if (pos_r == POS_LEN)   len_nxt = rx_byte;
      if (pos_r == POS_ID0)   first_nxt = rx_byte;
      if ((pos_r >= POS_ID0) && (pos_r <= POS_ID3)) begin
        id_ok_nxt = (pos_r == POS_ID0) ? same : (id_ok_r && same);
      end
      if (pos_r != POS_START) sum_nxt = sum_r + prev_r;
      prev_nxt = rx_byte;
      if (pos_r != POS_MAX) pos_nxt = pos_r + 9'd1;
      if ((pos_r >= POS_PAYLOAD) && ({1'b0, pos_r} < payload_end)) begin
        emitted_nxt        = emitted_r + 8'd1;
        res_valid          = 1'b1;
        res.payload_byte   = stripped;
        res.payload_length = emitted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r       <= '0;
      pos_r      <= '0;
      sum_r      <= '0;
      prev_r     <= '0;
      start_ok_r <= 1'b0;
      mark2_ok_r <= 1'b0;
      ctrl_r     <= '0;
      len_r      <= '0;
      first_r    <= '0;
      id_ok_r    <= 1'b0;
      emitted_r  <= '0;
    end else begin
      if (cfg_we) id_r <= cfg_wdata;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      prev_r     <= prev_nxt;
      start_ok_r <= start_ok_nxt;
      mark2_ok_r <= mark2_ok_nxt;
      ctrl_r     <= ctrl_nxt;
      len_r      <= len_nxt;
      first_r    <= first_nxt;
      id_ok_r    <= id_ok_nxt;
      emitted_r  <= emitted_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && frame_end) |=> (pos_r == '0 && emitted_r == '0))
    else $error("frame state not cleared after final byte");

  a_payload_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.is_status) |=> (emitted_r == $past(emitted_r) + 8'd1))
    else $error("payload count did not advance");

  a_pos_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !frame_end) |=> (pos_r >= $past(pos_r) && pos_r != '0))
    else $error("byte position went backward");
`endif

endmodule

// ----- rtl/core/mrd_out_queue.sv -----
// Two-entry result queue that decouples the result channel from the input.
module mrd_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mrd_pkg::mrd_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mrd_pkg::mrd_result_t out_data
);
  import mrd_pkg::*;

  mrd_result_t slot0_r, slot0_nxt;
  mrd_result_t slot1_r, slot1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = slot0_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) slot0_nxt = push_data;
        else slot1_nxt = push_data;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        cnt_nxt   = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          slot0_nxt = push_data;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("queue count wrong after transfer");
`endif

endmodule
